>>> rtl/fatan2_pkg.sv
package fatan2_pkg;

   localparam int R_WIDTH    = 16;
   localparam int Q_WIDTH    = 17;
   localparam int R2_WIDTH   = 31;
   localparam int T_WIDTH    = 28;
   localparam int T_SHIFT    = 30;
   localparam int P_WIDTH    = 31;
   localparam int PR_WIDTH   = 47;
   localparam int A_WIDTH    = 48;
   localparam int MAG_WIDTH  = 47;
   localparam int POLY_FRAC  = 45;

   localparam logic [T_WIDTH-1:0] COEF_SQ_Q30  = 28'd210775520;
   localparam logic [P_WIDTH-1:0] COEF_LIN_Q30 = 31'd1054092349;
   localparam logic [31:0]        PI_Q30       = 32'd3373259426;

   localparam logic [A_WIDTH-1:0] PI_Q45            = {1'b0, PI_Q30, 15'd0};
   localparam logic [A_WIDTH-1:0] QUARTER_PI_Q45    = {3'b000, PI_Q30, 13'd0};
   localparam logic [A_WIDTH-1:0] THREE_QTR_PI_Q45  = QUARTER_PI_Q45 * 48'd3;

   localparam logic signed [R_WIDTH-1:0] R_MIN = 16'sh8000;
   localparam logic signed [R_WIDTH-1:0] R_MAX = 16'sh7fff;

   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic n_neg;
      logic den_zero;
   } fatan2_flags_type;

endpackage

>>> rtl/fast_atan2_approximation.sv
// Four-quadrant arctangent of a signed (y, x) pair as a Q3.ANGLE_FRAC_BITS angle in
// radians, from a cubic fit on the ratio (x - sgn(x)|y|)/(|y|+|x|), rounded and limited
// to +-pi. One request per cycle is taken while req_stall is low; each request passes
// through the abs and difference stages, then the ratio divider, which resolves one of
// its 17 quotient bits per pipeline stage, then the multiply and rounding stages. A
// two-entry output buffer lets the pipeline keep taking requests while a result waits;
// req_stall rises only when both entries are full. Both inputs zero yields about +pi/2.
module fast_atan2_approximation #(
   parameter int INPUT_WIDTH     = 16,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [INPUT_WIDTH-1:0]     req_y_value,
   input  logic signed [INPUT_WIDTH-1:0]     req_x_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ANGLE_FRAC_BITS+2:0] rsp_angle
);
   import fatan2_pkg::*;

   localparam int W    = INPUT_WIDTH;
   localparam int OW   = ANGLE_FRAC_BITS + 3;
   localparam int SH   = POLY_FRAC - ANGLE_FRAC_BITS;
   localparam int NS   = Q_WIDTH + 10;
   localparam int ST_R = Q_WIDTH + 2;
   localparam logic [A_WIDTH-1:0] ROUND_HALF = 48'd1 << (SH - 1);
   localparam logic [A_WIDTH-1:0] ANGLE_LIM  = (PI_Q45 + ROUND_HALF) >> SH;
   localparam logic [OW-1:0]      LIM_OUT    = ANGLE_LIM[OW-1:0];

   logic en;
   logic [NS-1:0] valid_ff, valid_in;

   // abs stage
   logic [W-1:0]     ay_ff, ax_ff, ay_in, ax_in;
   fatan2_flags_type fl0_ff, fl0_in;
   // diff stage
   logic [W:0]       den_ff, an_ff, den_in, an_in, d;
   fatan2_flags_type fl1_ff, fl1_in;
   // divider
   logic [Q_WIDTH-1:0] div_q;
   fatan2_flags_type   div_fl;
   // ratio
   logic [Q_WIDTH:0]          qsum;
   logic [Q_WIDTH-1:0]        qh, qneg;
   logic signed [R_WIDTH-1:0] r_ff, r_in;
   fatan2_flags_type          flr_ff;
   // square
   logic signed [2*R_WIDTH-1:0] r_sq;
   logic [R2_WIDTH-1:0]         r2_ff;
   logic signed [R_WIDTH-1:0]   rd1_ff;
   fatan2_flags_type            fl2_ff;
   // scaled square
   logic [T_WIDTH+R2_WIDTH-1:0] t_prod;
   logic [T_WIDTH-1:0]          t_ff;
   logic signed [R_WIDTH-1:0]   rd2_ff;
   fatan2_flags_type            flt_ff;
   // polynomial
   logic signed [P_WIDTH-1:0]   p_ff, p_in;
   logic signed [R_WIDTH-1:0]   rd3_ff;
   fatan2_flags_type            flp_ff;
   // times r
   logic signed [PR_WIDTH-1:0]  pr_ff, pr_in;
   fatan2_flags_type            flpr_ff;
   // base add
   logic signed [A_WIDTH-1:0]   a_ff, a_in;
   fatan2_flags_type            fla_ff;
   // magnitude
   logic [MAG_WIDTH-1:0]        mag_ff, mag_in;
   fatan2_flags_type            flm_ff;
   // round, limit, sign
   logic [A_WIDTH-1:0]          rnd, rsh, sat;
   logic [OW-1:0]               res_mag;
   logic [OW-1:0]               res_ff, res_in;
   // output register and skid
   logic          rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   logic [OW-1:0] rsp_angle_ff, rsp_angle_in, skid_angle_ff, skid_angle_in;
   logic          out_take, last;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign valid_in  = en ? {valid_ff[NS-2:0], req_valid} : valid_ff;

   always_comb begin
      fl0_in          = '0;
      fl0_in.y_neg    = req_y_value[W-1];
      fl0_in.x_neg    = req_x_value[W-1];
      ay_in           = fl0_in.y_neg ? (~req_y_value + 1'b1) : req_y_value;
      ax_in           = fl0_in.x_neg ? (~req_x_value + 1'b1) : req_x_value;

      d               = {1'b0, ax_ff} - {1'b0, ay_ff};
      den_in          = {1'b0, ay_ff} + {1'b0, ax_ff};
      an_in           = d[W] ? (~d + 1'b1) : d;
      fl1_in          = fl0_ff;
      fl1_in.n_neg    = fl0_ff.x_neg ? (!d[W] && (d != '0)) : d[W];
      fl1_in.den_zero = (ay_ff == '0) && (ax_ff == '0);

      qsum = {1'b0, div_q} + 1'b1;
      qh   = qsum[Q_WIDTH:1];
      qneg = ~qh + 1'b1;
      if (div_fl.den_zero) begin
         r_in = R_MIN;
      end else if (div_fl.n_neg) begin
         r_in = signed'(qneg[R_WIDTH-1:0]);
      end else if (|qh[Q_WIDTH-1:R_WIDTH-1]) begin
         r_in = R_MAX;
      end else begin
         r_in = signed'(qh[R_WIDTH-1:0]);
      end

      r_sq   = r_ff * r_ff;
      t_prod = COEF_SQ_Q30 * r2_ff;
      p_in   = signed'({3'b000, t_ff} - COEF_LIN_Q30);
      pr_in  = p_ff * rd3_ff;
      a_in   = signed'(flpr_ff.x_neg ? THREE_QTR_PI_Q45 : QUARTER_PI_Q45)
               + A_WIDTH'(pr_ff);
      mag_in = a_ff[A_WIDTH-1] ? MAG_WIDTH'(-a_ff) : MAG_WIDTH'(a_ff);

      rnd     = {1'b0, mag_ff} + ROUND_HALF;
      rsh     = rnd >> SH;
      sat     = (rsh > ANGLE_LIM) ? ANGLE_LIM : rsh;
      res_mag = sat[OW-1:0];
      res_in  = flm_ff.y_neg ? (~res_mag + 1'b1) : res_mag;
   end

   fatan2_div #(
      .INPUT_WIDTH(W)
   ) u_div (
      .clock    (clock),
      .advance  (en),
      .num      (an_ff),
      .den      (den_ff),
      .flags_in (fl1_ff),
      .quot     (div_q),
      .flags_out(div_fl)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         ay_ff   <= ay_in;
         ax_ff   <= ax_in;
         fl0_ff  <= fl0_in;
         den_ff  <= den_in;
         an_ff   <= an_in;
         fl1_ff  <= fl1_in;
         r_ff    <= r_in;
         flr_ff  <= div_fl;
         r2_ff   <= r_sq[R2_WIDTH-1:0];
         rd1_ff  <= r_ff;
         fl2_ff  <= flr_ff;
         t_ff    <= t_prod[T_SHIFT +: T_WIDTH];
         rd2_ff  <= rd1_ff;
         flt_ff  <= fl2_ff;
         p_ff    <= p_in;
         rd3_ff  <= rd2_ff;
         flp_ff  <= flt_ff;
         pr_ff   <= pr_in;
         flpr_ff <= flp_ff;
         a_ff    <= a_in;
         fla_ff  <= flpr_ff;
         mag_ff  <= mag_in;
         flm_ff  <= fla_ff;
         res_ff  <= res_in;
      end
   end

   always_comb begin
      out_take      = rsp_valid_ff && !rsp_stall;
      last          = valid_ff[NS-1] && en;
      rsp_valid_in  = rsp_valid_ff;
      rsp_angle_in  = rsp_angle_ff;
      skid_valid_in = skid_valid_ff;
      skid_angle_in = skid_angle_ff;
      if (!rsp_valid_ff || out_take) begin
         rsp_valid_in  = skid_valid_ff || last;
         rsp_angle_in  = skid_valid_ff ? skid_angle_ff : res_ff;
         skid_valid_in = 1'b0;
      end else if (last) begin
         skid_valid_in = 1'b1;
         skid_angle_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_angle_ff  <= rsp_angle_in;
      skid_angle_ff <= skid_angle_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle = signed'(rsp_angle_ff);

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a pending output");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !out_take) |=> (skid_valid_ff && $stable(skid_angle_ff)))
      else $error("skid entry lost while output stalled");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (($signed(rsp_angle_ff) <= $signed(LIM_OUT)) &&
                        ($signed(rsp_angle_ff) >= -$signed(LIM_OUT))))
      else $error("angle outside +-pi");

   a_zero_ratio: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_R] && flr_ff.den_zero) |-> (r_ff == R_MIN))
      else $error("zero input pair did not force ratio to -1");

endmodule

>>> rtl/fatan2_div.sv
module fatan2_div #(
   parameter int INPUT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [INPUT_WIDTH:0]                num,
   input  logic [INPUT_WIDTH:0]                den,
   input  fatan2_pkg::fatan2_flags_type        flags_in,
   output logic [fatan2_pkg::Q_WIDTH-1:0]      quot,
   output fatan2_pkg::fatan2_flags_type        flags_out
);
   import fatan2_pkg::*;

   localparam int DW = INPUT_WIDTH + 1;

   // one restoring step per stage: quot = floor(num * 2^(Q_WIDTH-1) / den)
   logic [DW-1:0]      rem_ff [Q_WIDTH];
   logic [DW-1:0]      den_ff [Q_WIDTH];
   logic [Q_WIDTH-1:0] q_ff   [Q_WIDTH];
   fatan2_flags_type   fl_ff  [Q_WIDTH];

   for (genvar j = 0; j < Q_WIDTH; j++) begin : g_step
      logic [DW:0]        rem_sh;
      logic [DW-1:0]      den_src;
      logic [Q_WIDTH-1:0] q_src;
      fatan2_flags_type   fl_src;
      logic [DW:0]        diff;
      logic               take;
      logic [DW-1:0]      rem_in;
      logic [Q_WIDTH-1:0] q_in;

      if (j == 0) begin : g_first
         assign rem_sh  = {1'b0, num};
         assign den_src = den;
         assign q_src   = '0;
         assign fl_src  = flags_in;
      end else begin : g_next
         assign rem_sh  = {rem_ff[j-1], 1'b0};
         assign den_src = den_ff[j-1];
         assign q_src   = q_ff[j-1];
         assign fl_src  = fl_ff[j-1];
      end

      always_comb begin
         diff   = rem_sh - {1'b0, den_src};
         take   = rem_sh >= {1'b0, den_src};
         rem_in = take ? diff[DW-1:0] : rem_sh[DW-1:0];
         q_in   = {q_src[Q_WIDTH-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_src;
            q_ff[j]   <= q_in;
            fl_ff[j]  <= fl_src;
         end
      end
   end

   assign quot      = q_ff[Q_WIDTH-1];
   assign flags_out = fl_ff[Q_WIDTH-1];

endmodule
